>>> rtl/core/tvs_pkg.sv
// tvs_pkg: shared types and codes for the two-motor valve selector
// no dependencies; used by the interfaces' users, tvs_step and the top level
`default_nettype none

package tvs_pkg;

  localparam int TickW = 18;

  // request codes
  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpCmd  = 2'd1;
  localparam logic [1:0] OpInit = 2'd2;

  // sequence step codes
  localparam logic [2:0] StIdle          = 3'd0;
  localparam logic [2:0] StInitDrive     = 3'd1;
  localparam logic [2:0] StAllParkB      = 3'd2;
  localparam logic [2:0] StParkA         = 3'd3;
  localparam logic [2:0] StParkBThenDrv  = 3'd4;
  localparam logic [2:0] StParkAThenDrv  = 3'd5;
  localparam logic [2:0] StDrive         = 3'd6;
  localparam logic [2:0] StParkB         = 3'd7;

  // configuration register indexes
  localparam logic [1:0] RegNodeId       = 2'd0;
  localparam logic [1:0] RegBoxId        = 2'd1;
  localparam logic [1:0] RegUnitTicks    = 2'd2;
  localparam logic [1:0] RegReportPeriod = 2'd3;

  localparam logic [15:0] UnitTicksRst    = 16'd500;
  localparam logic [15:0] ReportPeriodRst = 16'd1000;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [1:0]  box_id;
    logic [15:0] unit_ticks;
    logic [15:0] report_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] dest_node;
    logic [7:0] dest_box;
    logic [7:0] cmd_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] motor_a_drive;
    logic [1:0] motor_b_drive;
    logic [3:0] valve_status;
    logic       send_report;
    logic       busy_res;
    logic       cmd_dropped;
  } result_t;

  typedef struct packed {
    logic [1:0]       pos_a;
    logic [1:0]       pos_b;
    logic             ready;
    logic [2:0]       step;
    logic [TickW-1:0] ticks;
    logic [2:0]       req;
    logic [15:0]      rpt;
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/tvs_in_if.sv
// tvs_in_if: valid/ready channel carrying one request transaction
// no dependencies
`default_nettype none

interface tvs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] dest_node;
  logic [7:0] dest_box;
  logic [7:0] cmd_byte;

  modport source (output valid, output op, output dest_node, output dest_box,
                  output cmd_byte, input ready);
  modport sink   (input valid, input op, input dest_node, input dest_box,
                  input cmd_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tvs_out_if.sv
// tvs_out_if: valid/ready channel carrying one result transaction
// no dependencies
`default_nettype none

interface tvs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_a_drive;
  logic [1:0] motor_b_drive;
  logic [3:0] valve_status;
  logic       send_report;
  logic       busy_res;
  logic       cmd_dropped;

  modport source (output valid, output motor_a_drive, output motor_b_drive,
                  output valve_status, output send_report, output busy_res,
                  output cmd_dropped, input ready);
  modport sink   (input valid, input motor_a_drive, input motor_b_drive,
                  input valve_status, input send_report, input busy_res,
                  input cmd_dropped, output ready);
endinterface

`default_nettype wire

>>> rtl/core/two_motor_valve_selector.sv
// two_motor_valve_selector: top level, input/result registers, state and config
// depends on tvs_pkg, tvs_in_if, tvs_out_if and tvs_step
//
// usage
// - in_if carries requests: tick, valve command or init; each accepted
//   transaction gives exactly one result transaction on out_if
// - cfg port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 node id, 1 box id, 2 ticks per unit, 3 report period); write only
//   while no transaction is in flight
// - a request is held in an input register, then one pass of logic updates
//   the motor/sequence state and loads the result register
// - the result register loads as the held request advances; while out_if
//   stalls, the request waits in the input register
// - throughput: one transaction per cycle while out_if takes each result,
//   as the state update in tvs_step is combinational
// - when out_if stalls, the input register still takes one more request;
//   in_if.ready then drops until the result is taken
// - reset: motors in the middle, not initialised, sequencer idle, report
//   counter at 1000 ticks, config at its defaults, both channels empty
`default_nettype none

module two_motor_valve_selector (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i,
  tvs_in_if.sink      in_if,
  tvs_out_if.source   out_if
);
  import tvs_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q, st_d;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    advance;

  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id       <= '0;
      cfg_q.box_id        <= '0;
      cfg_q.unit_ticks    <= UnitTicksRst;
      cfg_q.report_period <= ReportPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNodeId:       cfg_q.node_id       <= cfg_wdata_i[7:0];
        RegBoxId:        cfg_q.box_id        <= cfg_wdata_i[1:0];
        RegUnitTicks:    cfg_q.unit_ticks    <= cfg_wdata_i;
        RegReportPeriod: cfg_q.report_period <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q.op        <= in_if.op;
      item_q.dest_node <= in_if.dest_node;
      item_q.dest_box  <= in_if.dest_box;
      item_q.cmd_byte  <= in_if.cmd_byte;
    end
  end

  tvs_step u_step (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pos_a <= 2'd0;
      st_q.pos_b <= 2'd0;
      st_q.ready <= 1'b0;
      st_q.step  <= StIdle;
      st_q.ticks <= '0;
      st_q.req   <= 3'd0;
      st_q.rpt   <= ReportPeriodRst;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.motor_a_drive = res_q.motor_a_drive;
  assign out_if.motor_b_drive = res_q.motor_b_drive;
  assign out_if.valve_status  = res_q.valve_status;
  assign out_if.send_report   = res_q.send_report;
  assign out_if.busy_res      = res_q.busy_res;
  assign out_if.cmd_dropped   = res_q.cmd_dropped;

  a_busy_has_ticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.step != StIdle) |-> (st_q.ticks != '0))
    else $error("running sequence with empty move counter");

  a_advance_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed transaction produced no result");

  a_drop_only_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cmd_dropped) |-> res_q.busy_res)
    else $error("dropped request reported while idle");

  a_idle_motors_stopped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.busy_res) |->
      (res_q.motor_a_drive == 2'd0 && res_q.motor_b_drive == 2'd0))
    else $error("motor driven while sequencer idle");

endmodule

`default_nettype wire

>>> rtl/core/tvs_step.sv
// tvs_step: next-state and result logic for one request transaction
// depends on tvs_pkg
`default_nettype none

module tvs_step (
  input  tvs_pkg::cfg_t    cfg_i,
  input  tvs_pkg::state_t  st_i,
  input  tvs_pkg::item_t   item_i,
  output tvs_pkg::state_t  st_o,
  output tvs_pkg::result_t res_o
);
  import tvs_pkg::*;

  typedef struct packed {
    logic [2:0]       step;
    logic [TickW-1:0] ticks;
    logic             done;
  } enter_t;

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] d);
    return (d == '0) ? TickW'(1) : d;
  endfunction

  function automatic logic [2:0] next_step(input logic [2:0] s);
    logic [2:0] n;
    case (s)
      StInitDrive:    n = StAllParkB;
      StAllParkB:     n = StParkA;
      StParkBThenDrv: n = StDrive;
      StParkAThenDrv: n = StDrive;
      default:        n = StIdle;
    endcase
    return n;
  endfunction

  function automatic logic is_park_b(input logic [2:0] s);
    return (s == StAllParkB) || (s == StParkBThenDrv) || (s == StParkB);
  endfunction

  function automatic logic is_park_a(input logic [2:0] s);
    return (s == StParkA) || (s == StParkAThenDrv);
  endfunction

  // skips parks of motors already in the middle, then loads the move time
  function automatic enter_t enter_step(input logic [2:0] s, input logic [1:0] pa,
                                        input logic [1:0] pb, input logic [2:0] req,
                                        input logic [15:0] u);
    enter_t           e;
    logic [2:0]       cur;
    logic [TickW-1:0] u1, u2, u3, u4, half;
    logic [1:0]       pos;
    logic [2:0]       loc;
    cur  = s;
    u1   = {2'b00, u};
    u2   = {1'b0, u, 1'b0};
    u3   = u1 + u2;
    u4   = {u, 2'b00};
    half = {3'b000, u[15:1]};
    for (int i = 0; i < 2; i++) begin
      if ((is_park_b(cur) && pb == 2'd0) || (is_park_a(cur) && pa == 2'd0)) begin
        cur = next_step(cur);
      end
    end
    pos  = (req <= 3'd2) ? pa : pb;
    loc  = (req <= 3'd2) ? req : req - 3'd2;
    e.step = cur;
    e.done = 1'b0;
    if (cur == StIdle) begin
      e.ticks = '0;
      e.done  = 1'b1;
    end else if (cur == StInitDrive) begin
      e.ticks = at_least_one(u4);
    end else if (is_park_b(cur) || is_park_a(cur)) begin
      e.ticks = at_least_one(u1);
    end else if (pos == 2'd0) begin
      e.ticks = at_least_one(u2);
    end else if ({1'b0, pos} == loc) begin
      e.ticks = at_least_one(half);
    end else begin
      e.ticks = at_least_one(u3);
    end
    return e;
  endfunction

  state_t           st_d;
  enter_t           ent;
  logic             run_enter;
  logic [2:0]       enter_from;
  logic             flag;
  logic             dropped;
  logic [TickW-1:0] t_dec;
  logic [15:0]      r_dec;
  logic [6:0]       num;
  logic             open;
  logic [2:0]       req_m2;

  always_comb begin
    st_d       = st_i;
    run_enter  = 1'b0;
    enter_from = StIdle;
    flag       = 1'b0;
    dropped    = 1'b0;
    ent        = '0;
    t_dec      = (st_i.ticks != '0) ? st_i.ticks - TickW'(1) : st_i.ticks;
    r_dec      = (st_i.rpt != '0) ? st_i.rpt - 16'd1 : st_i.rpt;
    num        = item_i.cmd_byte[6:0];
    open       = item_i.cmd_byte[7];
    req_m2     = st_i.req - 3'd2;

    case (item_i.op)
      OpTick: begin
        if (st_i.step != StIdle) begin
          if (t_dec == '0) begin
            if (st_i.step == StInitDrive) begin
              st_d.pos_a = 2'd1;
              st_d.pos_b = 2'd1;
            end else if (is_park_b(st_i.step)) begin
              st_d.pos_b = 2'd0;
            end else if (is_park_a(st_i.step)) begin
              st_d.pos_a = 2'd0;
            end else if (st_i.req <= 3'd2) begin
              st_d.pos_a = st_i.req[1:0];
            end else begin
              st_d.pos_b = req_m2[1:0];
            end
            run_enter  = 1'b1;
            enter_from = next_step(st_i.step);
          end else begin
            st_d.ticks = t_dec;
          end
        end
        if (r_dec == '0) begin
          flag       = 1'b1;
          st_d.rpt   = (cfg_i.report_period != '0) ? cfg_i.report_period : 16'd1;
        end else begin
          st_d.rpt   = r_dec;
        end
      end
      OpCmd: begin
        if (item_i.dest_node == cfg_i.node_id && item_i.dest_box == {6'd0, cfg_i.box_id}) begin
          if (st_i.step != StIdle) begin
            dropped = 1'b1;
          end else if (st_i.ready) begin
            if (num == 7'd1 || num == 7'd2) begin
              st_d.req   = num[2:0];
              run_enter  = 1'b1;
              enter_from = open ? StParkBThenDrv : StParkA;
            end else if (num == 7'd3 || num == 7'd4) begin
              st_d.req   = num[2:0];
              run_enter  = 1'b1;
              enter_from = open ? StParkAThenDrv : StParkB;
            end else if (num == 7'd0 && !open) begin
              run_enter  = 1'b1;
              enter_from = StAllParkB;
            end else begin
              flag = 1'b1;
            end
          end
        end
      end
      OpInit: begin
        if (st_i.step != StIdle) begin
          dropped = 1'b1;
        end else begin
          st_d.ready = 1'b0;
          run_enter  = 1'b1;
          enter_from = StInitDrive;
        end
      end
      default: ;
    endcase

    if (run_enter) begin
      ent        = enter_step(enter_from, st_d.pos_a, st_d.pos_b, st_d.req,
                              cfg_i.unit_ticks);
      st_d.step  = ent.step;
      st_d.ticks = ent.ticks;
      if (ent.done) begin
        if (!st_d.ready) begin
          st_d.ready = 1'b1;
        end else begin
          flag = 1'b1;
        end
      end
    end
  end

  logic [2:0] req_d_m2;

  always_comb begin
    req_d_m2          = st_d.req - 3'd2;
    res_o             = '0;
    res_o.send_report = flag;
    res_o.cmd_dropped = dropped;
    res_o.busy_res    = (st_d.step != StIdle);
    case (st_d.step)
      StInitDrive: begin
        res_o.motor_a_drive = 2'd1;
        res_o.motor_b_drive = 2'd1;
      end
      StAllParkB, StParkBThenDrv, StParkB: begin
        res_o.motor_b_drive = (st_d.pos_b == 2'd1) ? 2'd2 : 2'd1;
      end
      StParkA, StParkAThenDrv: begin
        res_o.motor_a_drive = (st_d.pos_a == 2'd1) ? 2'd2 : 2'd1;
      end
      StDrive: begin
        if (st_d.req <= 3'd2) begin
          res_o.motor_a_drive = st_d.req[1:0];
        end else begin
          res_o.motor_b_drive = req_d_m2[1:0];
        end
      end
      default: ;
    endcase
    res_o.valve_status[0] = (st_d.pos_a == 2'd1);
    res_o.valve_status[1] = (st_d.pos_a != 2'd1) && (st_d.pos_a != 2'd0);
    res_o.valve_status[2] = (st_d.pos_b == 2'd1);
    res_o.valve_status[3] = (st_d.pos_b != 2'd1) && (st_d.pos_b != 2'd0);
  end

  assign st_o = st_d;

endmodule

`default_nettype wire
